// ===== rtl/shs_pkg.sv =====
package shs_pkg;

    localparam int HASH_WIDTH = 32;
    localparam int OP_DEPTH   = 4;
    localparam int OP_PTR_W   = $clog2(OP_DEPTH);
    localparam int OP_CNT_W   = $clog2(OP_DEPTH + 1);
    localparam int OUT_DEPTH  = 2;
    localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 1);

    typedef logic [HASH_WIDTH-1:0] hash_t;

    typedef struct packed {
        logic        seed_valid;
        logic [31:0] seed;
        logic        mix_valid;
        logic [15:0] mix_lo;
        logic [15:0] mix_hi;
        logic        fin_valid;
        logic [23:0] tail;
        logic [1:0]  tail_count;
    } op_t;

endpackage

// ===== rtl/shs_front.sv =====
module shs_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [7:0]      data_byte,
    input  logic            first_byte,
    input  logic            last_byte,
    input  logic [31:0]     message_length,
    output logic            op_push,
    output shs_pkg::op_t    op
);

    logic [1:0]  pend_cnt_reg;
    logic [1:0]  pend_cnt_next;
    logic [23:0] pend_bytes_reg;
    logic [23:0] pend_bytes_next;
    logic [1:0]  cnt;
    logic [23:0] bytes;
    logic [1:0]  new_cnt;
    logic [23:0] new_bytes;
    logic        is_empty;

    always_comb
    begin
        cnt       = first_byte ? 2'd0 : pend_cnt_reg;
        bytes     = first_byte ? 24'd0 : pend_bytes_reg;
        is_empty  = first_byte && last_byte && (message_length == 32'd0);
        op        = '0;
        op.seed_valid = first_byte;
        op.seed       = is_empty ? 32'd0 : message_length;
        op.mix_valid  = !is_empty && (cnt == 2'd3);
        op.mix_lo     = bytes[15:0];
        op.mix_hi     = {data_byte, bytes[23:16]};
        if (is_empty || cnt == 2'd3)
        begin
            new_bytes = 24'd0;
            new_cnt   = 2'd0;
        end
        else
        begin
            new_bytes = bytes | (24'(data_byte) << {cnt, 3'b000});
            new_cnt   = cnt + 2'd1;
        end
        op.fin_valid  = last_byte;
        op.tail       = new_bytes;
        op.tail_count = new_cnt;
        op_push = accept && (first_byte || op.mix_valid || last_byte);
        if (!accept)
        begin
            pend_cnt_next   = pend_cnt_reg;
            pend_bytes_next = pend_bytes_reg;
        end
        else if (last_byte)
        begin
            pend_cnt_next   = 2'd0;
            pend_bytes_next = 24'd0;
        end
        else
        begin
            pend_cnt_next   = new_cnt;
            pend_bytes_next = new_bytes;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_cnt_reg   <= 2'd0;
            pend_bytes_reg <= 24'd0;
        end
        else
        begin
            pend_cnt_reg   <= pend_cnt_next;
            pend_bytes_reg <= pend_bytes_next;
        end
    end

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_byte |=> pend_cnt_reg == 2'd0 && pend_bytes_reg == 24'd0)
        else $error("pending bytes survive a last beat");

endmodule

// ===== rtl/shs_op_queue.sv =====
module shs_op_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  shs_pkg::op_t    push_op,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output shs_pkg::op_t    head_op
);

    shs_pkg::op_t                      mem_reg [shs_pkg::OP_DEPTH];
    logic [shs_pkg::OP_PTR_W-1:0]      wr_ptr_reg;
    logic [shs_pkg::OP_PTR_W-1:0]      rd_ptr_reg;
    logic [shs_pkg::OP_CNT_W-1:0]      cnt_reg;
    logic [shs_pkg::OP_CNT_W-1:0]      cnt_next;
    logic                              do_push;
    logic                              do_pop;

    assign full    = (cnt_reg == shs_pkg::OP_CNT_W'(shs_pkg::OP_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign head_op = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("op pushed into a full queue");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= shs_pkg::OP_CNT_W'(shs_pkg::OP_DEPTH))
        else $error("op queue count out of range");

endmodule

// ===== rtl/shs_back.sv =====
module shs_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            op_empty,
    input  shs_pkg::op_t    op,
    output logic            op_pop,
    output logic            empty,
    input  logic            pop,
    output logic [31:0]     hash_value
);

    function automatic shs_pkg::hash_t mix_group(shs_pkg::hash_t h_in,
                                                 logic [15:0] lo, logic [15:0] hi);
        shs_pkg::hash_t h;
        shs_pkg::hash_t t;
        h = h_in + shs_pkg::hash_t'(lo);
        t = (shs_pkg::hash_t'(hi) << 11) ^ h;
        h = (h << 16) ^ t;
        h = h + (h >> 11);
        return h;
    endfunction

    function automatic shs_pkg::hash_t tail_rule(shs_pkg::hash_t h_in,
                                                 logic [23:0] held, logic [1:0] count);
        shs_pkg::hash_t h;
        case (count)
            2'd3:
            begin
                h = h_in + shs_pkg::hash_t'(held[15:0]);
                h = h ^ (h << 16);
                h = h ^ (shs_pkg::hash_t'(held[23:16]) << 18);
                h = h + (h >> 11);
            end
            2'd2:
            begin
                h = h_in + shs_pkg::hash_t'(held[15:0]);
                h = h ^ (h << 11);
                h = h + (h >> 17);
            end
            2'd1:
            begin
                h = h_in + shs_pkg::hash_t'(held[7:0]);
                h = h ^ (h << 10);
                h = h + (h >> 1);
            end
            default:
            begin
                h = h_in;
            end
        endcase
        return h;
    endfunction

    function automatic shs_pkg::hash_t aval_a(shs_pkg::hash_t h_in);
        shs_pkg::hash_t h;
        h = h_in ^ (h_in << 3);
        h = h + (h >> 5);
        h = h ^ (h << 4);
        h = h + (h >> 17);
        return h;
    endfunction

    function automatic shs_pkg::hash_t aval_b(shs_pkg::hash_t h_in);
        shs_pkg::hash_t h;
        h = h_in ^ (h_in << 25);
        h = h + (h >> 6);
        return h;
    endfunction

    shs_pkg::hash_t                 acc_reg;
    shs_pkg::hash_t                 acc_next;
    shs_pkg::hash_t                 acc_mixed;
    logic                           adv;
    logic                           s1_valid_reg;
    shs_pkg::hash_t                 s1_h_reg;
    logic [23:0]                    s1_tail_reg;
    logic [1:0]                     s1_cnt_reg;
    logic                           s2_valid_reg;
    shs_pkg::hash_t                 s2_h_reg;
    logic                           s3_valid_reg;
    shs_pkg::hash_t                 s3_h_reg;
    shs_pkg::hash_t                 result;
    logic [31:0]                    out_mem_reg [shs_pkg::OUT_DEPTH];
    logic [shs_pkg::OUT_PTR_W-1:0]  out_wr_reg;
    logic [shs_pkg::OUT_PTR_W-1:0]  out_rd_reg;
    logic [shs_pkg::OUT_CNT_W-1:0]  out_cnt_reg;
    logic [shs_pkg::OUT_CNT_W-1:0]  out_cnt_next;
    logic                           out_push;
    logic                           out_pop;

    assign adv    = (out_cnt_reg != shs_pkg::OUT_CNT_W'(shs_pkg::OUT_DEPTH));
    assign op_pop = adv && !op_empty;
    assign result = aval_b(s3_h_reg);
    assign out_push = adv && s3_valid_reg;
    assign out_pop  = pop && !empty;
    assign empty      = (out_cnt_reg == '0);
    assign hash_value = out_mem_reg[out_rd_reg];

    always_comb
    begin
        acc_mixed = op.seed_valid ? shs_pkg::hash_t'(op.seed) : acc_reg;
        if (op.mix_valid)
        begin
            acc_mixed = mix_group(acc_mixed, op.mix_lo, op.mix_hi);
        end
        acc_next = acc_reg;
        if (op_pop)
        begin
            acc_next = op.fin_valid ? '0 : acc_mixed;
        end
        out_cnt_next = out_cnt_reg;
        if (out_push && !out_pop)
        begin
            out_cnt_next = out_cnt_reg + 1'b1;
        end
        else if (out_pop && !out_push)
        begin
            out_cnt_next = out_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_h_reg    <= acc_mixed;
            s1_tail_reg <= op.tail;
            s1_cnt_reg  <= op.tail_count;
            s2_h_reg    <= aval_a(tail_rule(s1_h_reg, s1_tail_reg, s1_cnt_reg));
            s3_h_reg    <= s2_h_reg;
        end
        if (out_push)
        begin
            out_mem_reg[out_wr_reg] <= result[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            out_wr_reg   <= '0;
            out_rd_reg   <= '0;
            out_cnt_reg  <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
            if (adv)
            begin
                s1_valid_reg <= op_pop && op.fin_valid;
                s2_valid_reg <= s1_valid_reg;
                s3_valid_reg <= s2_valid_reg;
            end
            if (out_push)
            begin
                out_wr_reg <= out_wr_reg + 1'b1;
            end
            if (out_pop)
            begin
                out_rd_reg <= out_rd_reg + 1'b1;
            end
            out_cnt_reg <= out_cnt_next;
        end
    end

    a_fin_clears_acc: assert property (@(posedge clk) disable iff (!rst_n)
        op_pop && op.fin_valid |=> acc_reg == '0)
        else $error("accumulator not cleared after final beat");

    a_out_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_cnt_reg <= shs_pkg::OUT_CNT_W'(shs_pkg::OUT_DEPTH))
        else $error("result buffer count out of range");

endmodule

// ===== rtl/string_hash_stream_core.sv =====
// A beat carrying last_byte is accepted into the op queue; its hash shows with empty low
// once it has passed the accumulator step, tail rule, avalanche and result buffer.
// Throughput: one byte per cycle while full is low, set by the back-end accumulator update.
// full rises when the 4-entry op queue fills; the back end stalls only on a full 2-entry
// result buffer. Reset (rst_n, asynchronous, active low) clears the accumulator,
// pending bytes, queues and pipeline valids; no clearing pass is needed.
module string_hash_stream_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        first_byte,
    input  logic        last_byte,
    input  logic [31:0] message_length,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] hash_value
);

    logic          accept;
    logic          op_push;
    shs_pkg::op_t  front_op;
    logic          op_empty;
    logic          op_pop;
    shs_pkg::op_t  head_op;

    assign accept = push && !full;

    shs_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .data_byte      (data_byte),
        .first_byte     (first_byte),
        .last_byte      (last_byte),
        .message_length (message_length),
        .op_push        (op_push),
        .op             (front_op)
    );

    shs_op_queue u_op_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (op_push),
        .push_op (front_op),
        .full    (full),
        .pop     (op_pop),
        .empty   (op_empty),
        .head_op (head_op)
    );

    shs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .op_empty   (op_empty),
        .op         (head_op),
        .op_pop     (op_pop),
        .empty      (empty),
        .pop        (pop),
        .hash_value (hash_value)
    );

endmodule

// ===== sim/tb_top.sv =====
module tb_top;

    localparam int BUSY_PCT   = 64;
    localparam int LIGHT_PCT  = 11;
    localparam int HOLD_BEATS = 120;
    localparam int RAND_BEATS = 400;
    localparam int N_DIRECTED = 25;

    typedef struct packed {
        logic [7:0]      data;
        logic            first;
        logic            last;
        logic [31:0]     length;
        logic            pinned;
        shs_pkg::hash_t  pinned_hash;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        last_byte;
    logic [31:0] message_length;
    logic        empty;
    logic        pop;
    logic [31:0] hash_value;

    shs_pkg::hash_t running_hash;
    logic [23:0]    held_bytes;
    logic [1:0]     held_count;
    shs_pkg::hash_t expected_hashes[$];
    shs_pkg::hash_t oldest_hash;
    int             mismatches = 0;
    int             beats_sent;
    int             send_idle_pct;
    int             recv_stall_pct;
    bit             long_hold = 1'b0;

    stim_row_t directed_rows [N_DIRECTED] = '{
        '{8'h00, 1'b1, 1'b1, 32'd0,          1'b1, 32'h0},
        '{8'hFF, 1'b1, 1'b1, 32'd0,          1'b1, 32'h0},
        '{8'h00, 1'b1, 1'b1, 32'd1,          1'b0, 32'h0},
        '{8'hFF, 1'b1, 1'b1, 32'd1,          1'b0, 32'h0},
        '{8'h61, 1'b1, 1'b0, 32'd2,          1'b0, 32'h0},
        '{8'h62, 1'b0, 1'b1, 32'hFFFF_FFFF,  1'b0, 32'h0},
        '{8'hFF, 1'b1, 1'b0, 32'd3,          1'b0, 32'h0},
        '{8'hFF, 1'b0, 1'b0, 32'h0,          1'b0, 32'h0},
        '{8'hFF, 1'b0, 1'b1, 32'h0,          1'b0, 32'h0},
        '{8'h00, 1'b1, 1'b0, 32'd4,          1'b0, 32'h0},
        '{8'h80, 1'b0, 1'b0, 32'h5555_5555,  1'b0, 32'h0},
        '{8'h7F, 1'b0, 1'b0, 32'hAAAA_AAAA,  1'b0, 32'h0},
        '{8'hFF, 1'b0, 1'b1, 32'h0,          1'b0, 32'h0},
        '{8'h01, 1'b1, 1'b0, 32'hFFFF_FFFF,  1'b0, 32'h0},
        '{8'h02, 1'b0, 1'b0, 32'h0,          1'b0, 32'h0},
        '{8'h03, 1'b0, 1'b0, 32'h0,          1'b0, 32'h0},
        '{8'h04, 1'b0, 1'b0, 32'h0,          1'b0, 32'h0},
        '{8'h05, 1'b0, 1'b1, 32'h0,          1'b0, 32'h0},
        '{8'h5A, 1'b0, 1'b0, 32'h0000_1234,  1'b0, 32'h0},
        '{8'h00, 1'b0, 1'b1, 32'h0,          1'b0, 32'h0},
        '{8'h77, 1'b1, 1'b0, 32'd0,          1'b0, 32'h0},
        '{8'h88, 1'b0, 1'b1, 32'h0,          1'b0, 32'h0},
        '{8'h11, 1'b1, 1'b0, 32'd3,          1'b0, 32'h0},
        '{8'h22, 1'b1, 1'b0, 32'd2,          1'b0, 32'h0},
        '{8'h33, 1'b0, 1'b1, 32'h0,          1'b0, 32'h0}
    };

    string_hash_stream_core u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .data_byte      (data_byte),
        .first_byte     (first_byte),
        .last_byte      (last_byte),
        .message_length (message_length),
        .empty          (empty),
        .pop            (pop),
        .hash_value     (hash_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3000000;
        $display("FAILURE");
        $finish;
    end

    task automatic report_mismatch(input string what, input shs_pkg::hash_t want,
                                   input shs_pkg::hash_t got);
        $display("mismatch at %0t: %s, expected %08h, got %08h", $time, what, want, got);
        mismatches++;
    endtask

    task automatic absorb_byte(input logic [7:0] b, input logic fst, input logic lst,
                               input logic [31:0] len, output logic got,
                               output shs_pkg::hash_t digest);
        shs_pkg::hash_t h;
        shs_pkg::hash_t t;
        logic [15:0]    hi;
        got    = 1'b0;
        digest = '0;
        if (fst && lst && len == 32'd0)
        begin
            running_hash = '0;
            held_bytes   = '0;
            held_count   = '0;
            got          = 1'b1;
        end
        else
        begin
            if (fst)
            begin
                running_hash = shs_pkg::hash_t'(len);
                held_bytes   = '0;
                held_count   = '0;
            end
            if (held_count == 2'd3)
            begin
                hi = {b, held_bytes[23:16]};
                h  = running_hash + shs_pkg::hash_t'(held_bytes[15:0]);
                t  = (shs_pkg::hash_t'(hi) << 11) ^ h;
                h  = (h << 16) ^ t;
                running_hash = h + (h >> 11);
                held_bytes   = '0;
                held_count   = '0;
            end
            else
            begin
                held_bytes[8*held_count +: 8] = b;
                held_count = held_count + 2'd1;
            end
            if (lst)
            begin
                h = running_hash;
                case (held_count)
                    2'd3:
                    begin
                        h = h + shs_pkg::hash_t'(held_bytes[15:0]);
                        h = h ^ (h << 16);
                        h = h ^ (shs_pkg::hash_t'(held_bytes[23:16]) << 18);
                        h = h + (h >> 11);
                    end
                    2'd2:
                    begin
                        h = h + shs_pkg::hash_t'(held_bytes[15:0]);
                        h = h ^ (h << 11);
                        h = h + (h >> 17);
                    end
                    2'd1:
                    begin
                        h = h + shs_pkg::hash_t'(held_bytes[7:0]);
                        h = h ^ (h << 10);
                        h = h + (h >> 1);
                    end
                    default: ;
                endcase
                h = h ^ (h << 3);
                h = h + (h >> 5);
                h = h ^ (h << 4);
                h = h + (h >> 17);
                h = h ^ (h << 25);
                h = h + (h >> 6);
                digest       = h;
                got          = 1'b1;
                running_hash = '0;
                held_bytes   = '0;
                held_count   = '0;
            end
        end
    endtask

    task automatic send_beat(input logic [7:0] b, input logic fst, input logic lst,
                             input logic [31:0] len, input logic pin,
                             input shs_pkg::hash_t pinned);
        logic           took;
        logic           got;
        shs_pkg::hash_t digest;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push           <= 1'b1;
        data_byte      <= b;
        first_byte     <= fst;
        last_byte      <= lst;
        message_length <= len;
        took = 1'b0;
        while (!took)
        begin
            @(negedge clk);
            took = !full;
            @(posedge clk);
        end
        absorb_byte(b, fst, lst, len, got, digest);
        if (got)
            expected_hashes.push_back(pin ? pinned : digest);
        beats_sent++;
    endtask

    task automatic send_string(input int n, input logic [31:0] len, input logic with_first);
        if (n == 0)
            send_beat(8'($urandom), 1'b1, 1'b1, 32'd0, 1'b0, '0);
        for (int i = 0; i < n; i++)
            send_beat(8'($urandom), with_first && i == 0, i == n - 1,
                      (i == 0) ? len : $urandom, 1'b0, '0);
    endtask

    task automatic drain;
        push <= 1'b0;
        while (expected_hashes.size() != 0)
            @(posedge clk);
    endtask

    // receiver side
    initial
    begin
        bit hold_done;
        hold_done = 1'b0;
        pop       = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold && !hold_done)
            begin
                hold_done = 1'b1;
                for (int i = 0; i < HOLD_BEATS; i++)
                begin
                    pop <= 1'b0;
                    @(posedge clk);
                end
            end
            pop <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (expected_hashes.size() == 0)
                report_mismatch("hash with none pending", '0, hash_value);
            else
            begin
                oldest_hash = expected_hashes.pop_front();
                if (hash_value !== oldest_hash)
                    report_mismatch("hash_value", oldest_hash, hash_value);
            end
        end
    end

    initial
    begin
        int          n;
        int          r;
        logic [31:0] len;
        rst_n          = 1'b0;
        push           = 1'b0;
        data_byte      = '0;
        first_byte     = 1'b0;
        last_byte      = 1'b0;
        message_length = '0;
        running_hash   = '0;
        held_bytes     = '0;
        held_count     = '0;
        beats_sent     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_beat(directed_rows[i].data, directed_rows[i].first, directed_rows[i].last,
                      directed_rows[i].length, directed_rows[i].pinned,
                      directed_rows[i].pinned_hash);
        drain();

        // hold the receiver off and keep pushing until full stalls the input
        long_hold = 1'b1;
        for (int i = 0; i < 24; i++)
            send_string(1, 32'd1, 1'b1);
        drain();

        beats_sent = 0;
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct  = (p == 1) ? BUSY_PCT : (p == 3) ? LIGHT_PCT : 0;
            recv_stall_pct = (p == 2) ? BUSY_PCT : (p == 3) ? LIGHT_PCT : 0;
            while (beats_sent < (p + 1) * RAND_BEATS / 4)
            begin
                r = $urandom_range(0, 99);
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
                if (r < 75)
                begin
                    len = ($urandom_range(0, 19) == 0) ? $urandom : n;
                    send_string(n, len, 1'b1);
                end
                else if (r < 85)
                    send_string($urandom_range(1, 8), $urandom, 1'b1);
                else if (r < 92)
                    send_string($urandom_range(1, 6), $urandom, 1'b0);
                else
                begin
                    len = ($urandom_range(0, 1) == 0) ? 32'd0 : $urandom;
                    send_beat(8'($urandom), 1'($urandom), 1'($urandom), len, 1'b0, '0);
                end
            end
            drain();
        end

        repeat (20) @(posedge clk);
        if (mismatches == 0 && expected_hashes.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
